// ===== design/chkt_pkg.sv =====
// shared constants and types for the chained hash key table
`default_nettype none
package chkt_pkg;
    localparam int CAPACITY    = 64;
    localparam int MAX_BUCKETS = 128;
    localparam int HASH_WORDS  = 256;
    localparam int TAG_BITS    = 16;

    localparam int ENTRY_W  = $clog2(CAPACITY);
    localparam int BUCKET_W = $clog2(MAX_BUCKETS);
    localparam int USED_W   = ENTRY_W + 1;
    localparam int HIDX_W   = $clog2(HASH_WORDS);
    localparam int KEY_BYTES = 12;
    localparam int BYTE_W   = $clog2(KEY_BYTES + 1);

    localparam int DEV_W   = 32;
    localparam int INO_W   = 64;
    localparam int TAGF_W  = 16;
    localparam int WORD_W  = 32;
    localparam int IN_W    = 2 + DEV_W + INO_W + TAGF_W + 8 + WORD_W;
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 2 + TAGF_W;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    // head entry: valid + index, entry link: valid + index
    localparam int HEAD_W  = 1 + ENTRY_W;
    localparam int ENT_W   = DEV_W + INO_W + TAG_BITS + 1 + ENTRY_W;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [DEV_W-1:0]    dev;
        logic [INO_W-1:0]    ino;
        logic [TAG_BITS-1:0] tag;
        logic                link_vld;
        logic [ENTRY_W-1:0]  link;
    } entry_t;

    // hash unit request and reply
    typedef struct packed {
        logic             start;
        logic [2:0]       bits;
    } hreq_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] bucket;
    } hrsp_t;
endpackage
`default_nettype wire

// ===== design/chkt_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module chkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/chkt_hash.sv =====
// tabulation hash unit: one hash word read per key byte
`default_nettype none
module chkt_hash
    import chkt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hreq_t              req,
    input  wire logic [DEV_W-1:0]   dev,
    input  wire logic [INO_W-1:0]   ino,
    input  wire logic               load_we,
    input  wire logic [HIDX_W-1:0]  load_idx,
    input  wire logic [WORD_W-1:0]  load_data,
    output hrsp_t                   rsp
);
    logic [BYTE_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              rvld_reg, rvld_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [2:0]        bits_reg;
    logic              done_reg, done_next;
    logic [DEV_W+INO_W-1:0] key;
    logic [BYTE_W-1:0] sel;
    logic [HIDX_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic [2:0]        b;
    logic [WORD_W-1:0] mask;

    assign key = {ino, dev};
    assign sel = (cnt_reg < BYTE_W'(KEY_BYTES)) ? cnt_reg : '0;
    assign raddr = load_we ? load_idx : key[sel*8 +: 8];

    chkt_ram #(.WIDTH(WORD_W), .DEPTH(HASH_WORDS)) u_words (
        .aclk (aclk),
        .we   (load_we),
        .addr (raddr),
        .wdata(load_data),
        .rdata(rdata)
    );

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rvld_next = 1'b0;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (rvld_reg) begin
                acc_next = acc_reg ^ rdata;
            end
            if (cnt_reg < BYTE_W'(KEY_BYTES)) begin
                rvld_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end else if (!rvld_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rvld_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            rvld_reg <= rvld_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        if (req.start) begin
            bits_reg <= req.bits;
        end
    end

    assign b = (bits_reg == 3'd0) ? 3'd1 : bits_reg;
    assign mask = (WORD_W'(1) << b) - WORD_W'(1);

    assign rsp.done   = done_reg;
    assign rsp.bucket = BUCKET_W'(acc_reg & mask);
endmodule
`default_nettype wire

// ===== design/chkt_ctrl.sv =====
// command sequencer over the bucket and entry memories
`default_nettype none
module chkt_ctrl
    import chkt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire cmd_t                cmd,
    input  wire logic [DEV_W-1:0]    dev,
    input  wire logic [INO_W-1:0]    ino,
    input  wire logic [TAG_BITS-1:0] tag,
    input  wire hrsp_t               hrsp,
    output logic                     done,
    output status_t                  status,
    output logic [TAG_BITS-1:0]      found_tag
);
    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WAIT, S_INS_TAIL, S_INS_LINK_RD,
        S_INS_LINK_WR, S_WALK_RD, S_WALK_CHK, S_DONE
    } state_t;

    state_t              state_reg;
    logic [USED_W-1:0]   used_reg;
    logic [MAX_BUCKETS-1:0] hvld_reg;
    logic [BUCKET_W-1:0] bkt_reg;
    logic [ENTRY_W-1:0]  cur_reg;
    logic [USED_W-1:0]   steps_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [TAG_BITS-1:0] ftag_reg;

    logic                head_we;
    logic [ENTRY_W-1:0]  head_wdata, head_rdata;
    logic                tail_we;
    logic [ENTRY_W-1:0]  tail_rdata;
    logic                ent_we;
    logic [ENTRY_W-1:0]  ent_addr;
    entry_t              ent_wdata, ent_rdata;
    logic                ins;

    assign ins = (cmd == CMD_INSERT);

    chkt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BUCKETS)) u_head (
        .aclk(aclk), .we(head_we), .addr(bkt_reg), .wdata(head_wdata), .rdata(head_rdata)
    );
    chkt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BUCKETS)) u_tail (
        .aclk(aclk), .we(tail_we), .addr(bkt_reg), .wdata(used_reg[ENTRY_W-1:0]),
        .rdata(tail_rdata)
    );
    chkt_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_entry (
        .aclk(aclk), .we(ent_we), .addr(ent_addr), .wdata(ent_wdata), .rdata(ent_rdata)
    );

    always_comb begin
        head_we    = 1'b0;
        head_wdata = used_reg[ENTRY_W-1:0];
        tail_we    = 1'b0;
        ent_we     = 1'b0;
        ent_addr   = cur_reg;
        ent_wdata  = '{dev: dev, ino: ino, tag: tag, link_vld: 1'b0, link: '0};
        case (state_reg)
            S_INS_TAIL: begin
                ent_we   = 1'b1;
                ent_addr = used_reg[ENTRY_W-1:0];
                tail_we  = 1'b1;
                head_we  = !hvld_reg[bkt_reg];
            end
            S_INS_LINK_WR: begin
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                ent_wdata.link_vld = 1'b1;
                ent_wdata.link     = used_reg[ENTRY_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            hvld_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        status_reg <= ST_OK;
                        ftag_reg   <= '0;
                        if (ins && used_reg >= USED_W'(CAPACITY)) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (hrsp.done) begin
                        bkt_reg   <= hrsp.bucket;
                        state_reg <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: state_reg <= S_HEAD_WAIT;
                S_HEAD_WAIT: begin
                    if (ins) begin
                        state_reg <= S_INS_TAIL;
                    end else if (!hvld_reg[bkt_reg]) begin
                        status_reg <= ST_NOTFOUND;
                        state_reg  <= S_DONE;
                    end else begin
                        cur_reg   <= head_rdata;
                        steps_reg <= '0;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_INS_TAIL: begin
                    cur_reg <= tail_rdata;
                    if (hvld_reg[bkt_reg]) begin
                        state_reg <= S_INS_LINK_RD;
                    end else begin
                        hvld_reg[bkt_reg] <= 1'b1;
                        used_reg  <= used_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_INS_LINK_RD: state_reg <= S_INS_LINK_WR;
                S_INS_LINK_WR: begin
                    used_reg  <= used_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_WALK_RD: state_reg <= S_WALK_CHK;
                S_WALK_CHK: begin
                    if (ent_rdata.dev == dev && ent_rdata.ino == ino) begin
                        ftag_reg  <= ent_rdata.tag;
                        state_reg <= S_DONE;
                    end else if (!ent_rdata.link_vld
                                 || steps_reg == USED_W'(CAPACITY - 1)) begin
                        status_reg <= ST_NOTFOUND;
                        state_reg  <= S_DONE;
                    end else begin
                        cur_reg   <= ent_rdata.link;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_DONE: begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign found_tag = ftag_reg;
endmodule
`default_nettype wire

// ===== design/chained_hash_key_table.sv =====
// top level of the chained hash key table
//
// channel  dir  tdata fields (low bit first)                          tuser
// s_axis   in   cmd, device, inode, tag, word_index, word_data         -
// m_axis   out  status, found_tag                                      -
//
// load and no-op: result valid in the cycle after the input beat; insert and lookup
// hash the key, then read the bucket; lookup compares chain entries in turn
// the hash takes 12 reads of the single-port hash word ram, the chain walk
// one entry ram read per link
// a full insert answers with the full status without waiting for the hash
// reset clears bucket valid bits and the fill count; no clearing pass
// one beat in flight; s_tready drops until the result beat is taken
`default_nettype none
module chained_hash_key_table
    import chkt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_TW-1:0]  s_tdata,  // cmd, device, inode, tag, word_index, word_data
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_TW-1:0]      m_tdata   // status, found_tag
);
    logic [2:0]          bits_reg;
    logic                busy_reg;
    logic                ovld_reg;
    logic [OUT_W-1:0]    odata_reg;
    cmd_t                cmd_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [INO_W-1:0]    ino_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                acc;
    cmd_t                in_cmd;
    logic                load_we;
    logic                ctrl_start;
    logic                ctrl_done;
    status_t             ctrl_status;
    logic [TAG_BITS-1:0] ctrl_tag;
    hreq_t               hreq;
    hrsp_t               hrsp;

    assign s_tready = !busy_reg && !ovld_reg;
    assign acc      = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tdata[1:0]);
    assign load_we  = acc && in_cmd == CMD_LOAD;
    assign ctrl_start = acc && (in_cmd inside {CMD_INSERT, CMD_LOOKUP});

    always_ff @(posedge aclk) begin
        if (ctrl_start) begin
            cmd_reg <= in_cmd;
            dev_reg <= s_tdata[2 +: DEV_W];
            ino_reg <= s_tdata[34 +: INO_W];
            tag_reg <= s_tdata[98 +: TAG_BITS];
        end
    end

    // hash starts in the cycle after capture so key registers are stable
    logic hstart_reg;
    assign hreq.start = hstart_reg;
    assign hreq.bits  = bits_reg;

    chkt_hash u_hash (
        .aclk(aclk), .aresetn(aresetn), .req(hreq), .dev(dev_reg), .ino(ino_reg),
        .load_we(load_we), .load_idx(s_tdata[114 +: 8]), .load_data(s_tdata[122 +: 32]),
        .rsp(hrsp)
    );

    chkt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(hstart_reg), .cmd(cmd_reg),
        .dev(dev_reg), .ino(ino_reg), .tag(tag_reg), .hrsp(hrsp),
        .done(ctrl_done), .status(ctrl_status), .found_tag(ctrl_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg   <= 3'd7;
            busy_reg   <= 1'b0;
            ovld_reg   <= 1'b0;
            hstart_reg <= 1'b0;
        end else begin
            hstart_reg <= ctrl_start;
            if (cfg_we) begin
                bits_reg <= cfg_wdata;
            end
            if (ovld_reg && m_tready) begin
                ovld_reg <= 1'b0;
            end
            if (acc) begin
                if (ctrl_start) begin
                    busy_reg <= 1'b1;
                end else begin
                    ovld_reg  <= 1'b1;
                    odata_reg <= {16'd0, ST_OK};
                end
            end
            if (ctrl_done) begin
                busy_reg  <= 1'b0;
                ovld_reg  <= 1'b1;
                odata_reg <= {TAGF_W'(ctrl_tag), ctrl_status};
            end
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = OUT_TW'(odata_reg);
endmodule
`default_nettype wire

// ===== design/chkt_checker.sv =====
// port-level checker for the chained hash key table, bound to the top level
`default_nettype none
module chkt_checker
    import chkt_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_TW-1:0] m_tdata
);
    // result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // no new input while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken with result pending");

    // reserved status never reported
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != ST_RSVD)
        else $error("reserved status");

    // tag is zero unless found
    a_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[17:2] == 16'd0)
        else $error("tag on miss");
endmodule

bind chained_hash_key_table chkt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== bench/tb_chained_hash_key_table.sv =====
// self-checking testbench for the chained hash key table
`timescale 1ns / 1ps
`default_nettype none
module tb_chained_hash_key_table
    import chkt_pkg::*;
();
    typedef struct {
        status_t     st;
        logic [15:0] tag;
    } reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_TW-1:0] m_tdata;

    chained_hash_key_table dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the table
    logic [31:0]         hash_word [HASH_WORDS];
    bit                  head_vld [MAX_BUCKETS];
    logic [ENTRY_W-1:0]  head_idx [MAX_BUCKETS];
    logic [ENTRY_W-1:0]  tail_idx [MAX_BUCKETS];
    logic [31:0]         ent_dev [CAPACITY];
    logic [63:0]         ent_ino [CAPACITY];
    logic [15:0]         ent_tag [CAPACITY];
    bit                  ent_lvld [CAPACITY];
    logic [ENTRY_W-1:0]  ent_link [CAPACITY];
    int                  fill_count = 0;
    logic [2:0]          bucket_bits = 3'd7;

    reply_t      pending_replies[$];
    logic [31:0] known_dev[$];
    logic [63:0] known_ino[$];
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          hold_cycles = 0;
    bit          no_idle = 1'b0;

    function automatic int bucket_of(logic [31:0] dev, logic [63:0] ino);
        logic [31:0] h;
        int          bits;
        h = '0;
        for (int i = 0; i < 4; i++) h ^= hash_word[dev[8*i +: 8]];
        for (int i = 0; i < 8; i++) h ^= hash_word[ino[8*i +: 8]];
        bits = (bucket_bits == 0) ? 1 : int'(bucket_bits);
        return int'(h & ((32'd1 << bits) - 1)) % MAX_BUCKETS;
    endfunction

    function automatic reply_t apply_command(cmd_t cmd, logic [31:0] dev, logic [63:0] ino,
                                             logic [15:0] tag, logic [7:0] widx,
                                             logic [31:0] wdata);
        reply_t r;
        int     b;
        int     cur;
        bit     have;
        r.st  = ST_OK;
        r.tag = '0;
        case (cmd)
            CMD_LOAD: begin
                hash_word[widx] = wdata;
            end
            CMD_INSERT: begin
                if (fill_count >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    b = bucket_of(dev, ino);
                    ent_dev[fill_count]  = dev;
                    ent_ino[fill_count]  = ino;
                    ent_tag[fill_count]  = tag;
                    ent_lvld[fill_count] = 1'b0;
                    ent_link[fill_count] = '0;
                    if (head_vld[b]) begin
                        ent_lvld[tail_idx[b]] = 1'b1;
                        ent_link[tail_idx[b]] = fill_count[ENTRY_W-1:0];
                    end else begin
                        head_vld[b] = 1'b1;
                        head_idx[b] = fill_count[ENTRY_W-1:0];
                    end
                    tail_idx[b] = fill_count[ENTRY_W-1:0];
                    fill_count++;
                end
            end
            CMD_LOOKUP: begin
                b    = bucket_of(dev, ino);
                have = head_vld[b];
                cur  = int'(head_idx[b]);
                r.st = ST_NOTFOUND;
                for (int s = 0; s < CAPACITY && have; s++) begin
                    if (ent_dev[cur] == dev && ent_ino[cur] == ino) begin
                        r.st  = ST_OK;
                        r.tag = ent_tag[cur];
                        break;
                    end
                    have = ent_lvld[cur];
                    cur  = int'(ent_link[cur]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_command(cmd_t cmd, logic [31:0] dev, logic [63:0] ino,
                                logic [15:0] tag, logic [7:0] widx, logic [31:0] wdata);
        bit first;
        first = 1'b1;
        if (!no_idle) begin
            while ($urandom_range(99) < 15) begin
                if (first) s_tvalid <= 1'b0;
                first = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, wdata, widx, tag, ino, dev, cmd};
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(apply_command(cmd, dev, ino, tag, widx, wdata));
        if (cmd == CMD_INSERT && fill_count <= CAPACITY) begin
            known_dev.push_back(dev);
            known_ino.push_back(ino);
        end
        beats_in++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    task automatic write_bucket_bits(logic [2:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we      <= 1'b0;
        bucket_bits  = v;
    endtask

    // receiver side
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[1:0] !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st,
                             m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[17:2] !== want.tag) begin
                    $display("%0t: found_tag expected %h actual %h", $time, want.tag,
                             m_tdata[17:2]);
                    errors++;
                end
            end
        end
    end

    task automatic test_load_words();
        for (int i = 0; i < HASH_WORDS; i++)
            send_command(CMD_LOAD, $urandom, {$urandom, $urandom}, 16'($urandom), i[7:0],
                         $urandom);
        send_command(CMD_LOAD, '0, '0, '0, 8'd0, 32'hFFFF_FFFF);
        send_command(CMD_LOAD, '1, '1, '1, 8'd255, 32'h0);
    endtask

    task automatic test_directed();
        send_command(CMD_LOOKUP, 32'h1, 64'h2, '0, '0, '0);
        send_command(CMD_INSERT, '0, '0, 16'h0000, '1, '1);
        send_command(CMD_INSERT, '1, '1, 16'hFFFF, '0, '0);
        send_command(CMD_INSERT, '0, '1, 16'h1234, '0, '0);
        send_command(CMD_INSERT, '1, '0, 16'hABCD, '0, '0);
        // duplicate key keeps the earlier tag
        send_command(CMD_INSERT, '0, '0, 16'h5555, '0, '0);
        send_command(CMD_LOOKUP, '0, '0, '1, '1, '1);
        send_command(CMD_LOOKUP, '1, '1, '0, '0, '0);
        send_command(CMD_LOOKUP, '0, '1, '0, '0, '0);
        send_command(CMD_LOOKUP, '1, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 32'h8000_0000, 64'h1, '0, '0, '0);
        send_command(CMD_NOP, '1, '1, '1, '1, '1);
        send_command(CMD_NOP, '0, '0, '0, '0, '0);
        // zero bucket bits behaves as one
        write_bucket_bits(3'd0);
        send_command(CMD_INSERT, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 16'h0F0F, '0, '0);
        send_command(CMD_LOOKUP, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, '0, '0, '0);
        send_command(CMD_LOOKUP, '1, '1, '0, '0, '0);
        write_bucket_bits(3'd1);
        send_command(CMD_LOOKUP, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 300;
        for (int i = 0; i < 6; i++)
            send_command(CMD_LOOKUP, known_dev[0], known_ino[0], '0, '0, '0);
        wait_idle();
    endtask

    task automatic random_command();
        int          r;
        int          k;
        logic [31:0] dev;
        logic [63:0] ino;
        r   = $urandom_range(99);
        dev = $urandom;
        ino = {$urandom, $urandom};
        if (known_dev.size() != 0 && $urandom_range(99) < 75) begin
            k   = $urandom_range(known_dev.size() - 1);
            dev = known_dev[k];
            ino = known_ino[k];
        end
        if (r < 8)
            send_command(CMD_LOAD, dev, ino, 16'($urandom), 8'($urandom), $urandom);
        else if (r < 30)
            send_command(CMD_INSERT, $urandom, {$urandom, $urandom}, 16'($urandom),
                         8'($urandom), $urandom);
        else if (r < 35)
            send_command(CMD_INSERT, dev, ino, 16'($urandom), 8'($urandom), $urandom);
        else if (r < 95)
            send_command(CMD_LOOKUP, dev, ino, 16'($urandom), 8'($urandom), $urandom);
        else
            send_command(CMD_NOP, dev, ino, 16'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic test_random(logic [2:0] bits, int n, bit steady);
        write_bucket_bits(bits);
        no_idle = steady;
        for (int i = 0; i < n; i++) random_command();
        no_idle = 1'b0;
    endtask

    task automatic test_table_full();
        while (fill_count < CAPACITY)
            send_command(CMD_INSERT, $urandom, {$urandom, $urandom}, 16'($urandom), '0, '0);
        send_command(CMD_INSERT, '1, '1, '1, '1, '1);
        send_command(CMD_INSERT, '0, '0, '0, '0, '0);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_load_words();
        test_directed();
        test_backpressure();
        test_random(3'd7, 150, 1'b0);
        test_random(3'd2, 150, 1'b1);
        test_table_full();
        test_random(3'd1, 150, 1'b0);
        test_random(3'd0, 120, 1'b0);
        test_random(3'd5, 150, 1'b0);
        test_random(3'd3, 150, 1'b0);
        test_random(3'd6, 150, 1'b0);
        test_random(3'd4, 150, 1'b0);
        test_random(3'd7, 100, 1'b0);
        wait_idle();
        $display("sent %0d beats, checked %0d result beats", beats_in, beats_out);
        $display("covered hash loads, inserts to full, chain lookups and all bucket sizes");
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
